// File: src/qdlp_pkg.sv
package qdlp_pkg;

   // register indexes on the csr port
   localparam logic [2:0] CSR_STEPS_PER_DETENT = 3'd0;
   localparam logic [2:0] CSR_LONG_PRESS_MS    = 3'd1;
   localparam logic [2:0] CSR_ACTIVE_LOW       = 3'd2;
   localparam logic [2:0] CSR_ENCODER_ENABLED  = 3'd3;
   localparam logic [2:0] CSR_BUTTON_ENABLED   = 3'd4;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   // register reset values
   localparam logic [4:0]  STEPS_PER_DETENT_RESET = 5'd4;
   localparam logic [15:0] LONG_PRESS_MS_RESET    = 16'd500;

   // detent size limits
   localparam logic [4:0] DETENT_MIN = 5'd1;
   localparam logic [4:0] DETENT_MAX = 5'd16;

   // navigation step codes
   localparam logic signed [1:0] NAV_NONE = 2'sd0;
   localparam logic signed [1:0] NAV_NEXT = 2'sd1;
   localparam logic signed [1:0] NAV_PREV = -2'sd1;

   typedef struct packed {
      logic        level_a;
      logic        level_b;
      logic        button_level;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic signed [1:0] nav_step;
      logic              select_event;
      logic              back_event;
   } rsp_type;

   // quadrature transition table, index is {prev_ab, ab}
   function automatic logic signed [1:0] quad_dir(input logic [3:0] idx);
      logic signed [1:0] dir;
      unique case (idx)
         4'd1, 4'd7, 4'd8, 4'd14: dir = NAV_PREV;
         4'd2, 4'd4, 4'd11, 4'd13: dir = NAV_NEXT;
         default: dir = NAV_NONE;
      endcase
      return dir;
   endfunction

endpackage

// File: src/quadrature_detent_long_press.sv
// Quadrature encoder and push-button decoder. Each accepted sample (A/B levels,
// raw button level, millisecond timestamp) yields exactly one result: a
// navigation step of +1/-1/0 once a full detent of steps_per_detent counts has
// accumulated, a select event on release of a short press, and a single back
// event once a press has been held long_press_ms or more (wrapping time).
// A new sample can be taken every clock cycle; the result is registered on its
// transfer, held in a single output register whose stall back-pressures the
// input only while that register is full and stalled. The user must write
// registers through the csr port only while no sample is in flight; the block
// does not enforce this. csr_ready is always high.
module quadrature_detent_long_press (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  qdlp_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output qdlp_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [qdlp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [qdlp_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   // configuration registers
   logic [4:0]  steps_per_detent_ff;
   logic [15:0] long_press_ms_ff;
   logic        active_low_ff;
   logic        encoder_enabled_ff;
   logic        button_enabled_ff;

   // decoder state
   logic [1:0]        prev_ab_ff, prev_ab_in;
   logic signed [4:0] step_accum_ff, step_accum_in;
   logic              pressed_ff, pressed_in;
   logic [31:0]       press_start_ff, press_start_in;
   logic              press_handled_ff, press_handled_in;

   // output register
   logic              rsp_valid_ff;
   qdlp_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   logic              req_accept;
   logic              csr_write;
   logic [1:0]        ab;
   logic signed [1:0] dir;
   logic [4:0]        detent;
   logic signed [6:0] sum;
   logic signed [6:0] detent_s;
   logic              down;
   logic [31:0]       elapsed;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_per_detent_ff <= qdlp_pkg::STEPS_PER_DETENT_RESET;
         long_press_ms_ff    <= qdlp_pkg::LONG_PRESS_MS_RESET;
         active_low_ff       <= 1'b1;
         encoder_enabled_ff  <= 1'b1;
         button_enabled_ff   <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            qdlp_pkg::CSR_STEPS_PER_DETENT: steps_per_detent_ff <= csr_data[4:0];
            qdlp_pkg::CSR_LONG_PRESS_MS:    long_press_ms_ff    <= csr_data;
            qdlp_pkg::CSR_ACTIVE_LOW:       active_low_ff       <= csr_data[0];
            qdlp_pkg::CSR_ENCODER_ENABLED:  encoder_enabled_ff  <= csr_data[0];
            qdlp_pkg::CSR_BUTTON_ENABLED:   button_enabled_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // detent size clamped to 1..16
   always_comb begin
      priority if (steps_per_detent_ff < qdlp_pkg::DETENT_MIN) begin
         detent = qdlp_pkg::DETENT_MIN;
      end else if (steps_per_detent_ff > qdlp_pkg::DETENT_MAX) begin
         detent = qdlp_pkg::DETENT_MAX;
      end else begin
         detent = steps_per_detent_ff;
      end
   end

   // encoder path
   assign ab       = {req_payload.level_a, req_payload.level_b};
   assign dir      = qdlp_pkg::quad_dir({prev_ab_ff, ab});
   assign sum      = 7'(step_accum_ff) + 7'(dir);
   assign detent_s = $signed({2'b00, detent});

   // button path
   assign down    = active_low_ff ? !req_payload.button_level : req_payload.button_level;
   assign elapsed = req_payload.now_ms - press_start_ff;

   always_comb begin
      prev_ab_in       = prev_ab_ff;
      step_accum_in    = step_accum_ff;
      pressed_in       = pressed_ff;
      press_start_in   = press_start_ff;
      press_handled_in = press_handled_ff;
      rsp_payload_in.nav_step     = qdlp_pkg::NAV_NONE;
      rsp_payload_in.select_event = 1'b0;
      rsp_payload_in.back_event   = 1'b0;

      if (encoder_enabled_ff) begin
         prev_ab_in = ab;
         if (dir != qdlp_pkg::NAV_NONE) begin
            priority if (sum >= detent_s) begin
               step_accum_in = 5'(sum - detent_s);
               rsp_payload_in.nav_step = qdlp_pkg::NAV_NEXT;
            end else if (sum <= -detent_s) begin
               step_accum_in = 5'(sum + detent_s);
               rsp_payload_in.nav_step = qdlp_pkg::NAV_PREV;
            end else begin
               step_accum_in = 5'(sum);
            end
         end
      end

      if (button_enabled_ff) begin
         priority if (down && !pressed_ff) begin
            pressed_in       = 1'b1;
            press_start_in   = req_payload.now_ms;
            press_handled_in = 1'b0;
         end else if (down && !press_handled_ff) begin
            if (elapsed >= {16'd0, long_press_ms_ff}) begin
               press_handled_in = 1'b1;
               rsp_payload_in.back_event = 1'b1;
            end
         end else if (!down && pressed_ff) begin
            pressed_in = 1'b0;
            rsp_payload_in.select_event = !press_handled_ff;
         end else begin
            // released and idle, or a hold already reported
         end
      end
   end

   // state update per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ab_ff       <= 2'd0;
         step_accum_ff    <= 5'sd0;
         pressed_ff       <= 1'b0;
         press_start_ff   <= 32'd0;
         press_handled_ff <= 1'b0;
      end else if (req_accept) begin
         prev_ab_ff       <= prev_ab_in;
         step_accum_ff    <= step_accum_in;
         pressed_ff       <= pressed_in;
         press_start_ff   <= press_start_in;
         press_handled_ff <= press_handled_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   // checks
   a_no_double_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_payload_ff.select_event && rsp_payload_ff.back_event))
      else $error("select and back in one result");

   a_nav_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_payload_ff.nav_step != 2'b10))
      else $error("illegal nav step code");

   a_accum_range: assert property (@(posedge clock) disable iff (reset)
      step_accum_ff != -5'sd16)
      else $error("step accumulator out of range");

   a_back_needs_press: assert property (@(posedge clock) disable iff (reset)
      (req_accept && rsp_payload_in.back_event) |-> (pressed_ff && !press_handled_ff))
      else $error("back event without an open press");

   a_select_needs_press: assert property (@(posedge clock) disable iff (reset)
      (req_accept && rsp_payload_in.select_event) |=> !pressed_ff)
      else $error("select event without release");

endmodule
